@@ hw/rtl/qrs_pkg.sv @@
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int COEF_W   = 32;
    localparam int ROOT_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_REAL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIV = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SAT      = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        logic signed [ROOT_W-1:0] root_one;
        logic signed [ROOT_W-1:0] root_two;
        logic [STATUS_W-1:0]      status;
    } result_t;

endpackage

@@ hw/rtl/qrs_div.sv @@
// Restoring divider, one quotient bit per stage, a new item every cycle.
module qrs_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 36,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NUM_W-1:0] in_num,
    input  logic [DEN_W-1:0] in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] out_tag
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [NUM_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [NUM_W-1:0] quo_prev;
        logic [TAG_W-1:0] tag_prev;
        logic [DEN_W:0]   rem_sh;
        logic             ge;
        logic [DEN_W:0]   rem_dif;
        logic [DEN_W-1:0] rem_next;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = in_num;
            assign den_prev = in_den;
            assign quo_prev = '0;
            assign tag_prev = in_tag;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign tag_prev = tag_reg[k-1];
        end

        assign rem_sh   = {rem_prev, num_prev[NUM_W-1]};
        assign ge       = rem_sh >= {1'b0, den_prev};
        assign rem_dif  = rem_sh - {1'b0, den_prev};
        // remainder stays below the divisor, so the top bit drops
        assign rem_next = ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            num_reg[k] <= {num_prev[NUM_W-2:0], 1'b0};
            den_reg[k] <= den_prev;
            quo_reg[k] <= {quo_prev[NUM_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else
            begin
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign quo     = quo_reg[NUM_W-1];
    assign out_tag = tag_reg[NUM_W-1];

endmodule

@@ hw/rtl/quadratic_roots_stable.sv @@
// Pipeline from the accepting edge to the done strobe:
//   input, product, discriminant, 35 square root stages, root select,
//   36 + FRAC_BITS divider stages, output register.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// Reset (rst_n low, asynchronous): all valid bits clear, method returns to stable.
module quadratic_roots_stable #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  qrs_pkg::coef_t   coef,
    input  logic             cfg_we,
    input  logic             cfg_data,
    output logic             done,
    output qrs_pkg::result_t result
);

    localparam int CW       = qrs_pkg::COEF_W;
    localparam int D_W      = 2 * CW + 2;     // b*b + 4|ac| fits here
    localparam int SQ_N     = 35;             // root bits
    localparam int SQ_D_W   = 2 * SQ_N;       // padded radicand
    localparam int SQ_REM_W = SQ_N + 3;
    localparam int QS_W     = 37;             // signed -b +/- sqrt
    localparam int MAG_W    = 36;
    localparam int NUM_W    = MAG_W + FRAC_BITS;
    localparam int OUT_W    = (WORD_BITS < 32) ? WORD_BITS : 32;
    localparam logic [NUM_W-1:0] LIM = NUM_W'(1) << (OUT_W - 1);

    // side info that rides along the square root pipeline
    typedef struct packed {
        logic                 method;
        logic                 a_zero;
        logic                 no_real;
        logic                 a_neg;
        logic                 c_neg;
        logic signed [CW-1:0] b;
        logic [CW-1:0]        am;
        logic [CW-1:0]        cm;
    } sq_side_t;

    // control bundle that rides through the first divider
    typedef struct packed {
        logic                            vld;
        logic                            method;
        logic                            spec;
        logic [qrs_pkg::STATUS_W-1:0]    spec_code;
        logic                            b_neg;
        logic                            sgn;
    } tag_t;

    // result is never held off, so the pipeline just flows
    assign busy = 1'b0;

    logic method_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            method_reg <= cfg_data;
        end
    end

    // ---- stage 1: magnitudes and signs ----
    logic     s1_vld_reg;
    sq_side_t s1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_side_reg.method  <= method_reg;
        s1_side_reg.a_zero  <= coef.coef_a == '0;
        s1_side_reg.no_real <= 1'b0;
        s1_side_reg.a_neg   <= coef.coef_a[CW-1];
        s1_side_reg.c_neg   <= coef.coef_c[CW-1];
        s1_side_reg.b       <= coef.coef_b;
        s1_side_reg.am      <= coef.coef_a[CW-1] ? ~coef.coef_a + 1'b1 : coef.coef_a;
        s1_side_reg.cm      <= coef.coef_c[CW-1] ? ~coef.coef_c + 1'b1 : coef.coef_c;
    end

    // ---- stage 2: b*b and |a*c| ----
    logic            s2_vld_reg;
    sq_side_t        s2_side_reg;
    logic [2*CW-1:0] s2_bsq_reg;
    logic [2*CW-1:0] s2_ac_reg;
    logic [CW-1:0]   bm1;

    assign bm1 = s1_side_reg.b[CW-1] ? ~s1_side_reg.b + 1'b1 : s1_side_reg.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s1_side_reg;
        s2_bsq_reg  <= bm1 * bm1;
        s2_ac_reg   <= s1_side_reg.am * s1_side_reg.cm;
    end

    // ---- stage 3: discriminant ----
    logic           s3_vld_reg;
    sq_side_t       s3_side_reg;
    logic [D_W-1:0] s3_d_reg;
    logic [D_W-1:0] bsq_w;
    logic [D_W-1:0] ac4_w;
    logic           opp_sign;
    sq_side_t       s3_side_next;

    assign bsq_w    = {2'b00, s2_bsq_reg};
    assign ac4_w    = {s2_ac_reg, 2'b00};
    assign opp_sign = s2_side_reg.a_neg != s2_side_reg.c_neg;

    always_comb
    begin
        s3_side_next         = s2_side_reg;
        s3_side_next.no_real = !opp_sign && (bsq_w < ac4_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_side_reg <= s3_side_next;
        s3_d_reg    <= opp_sign ? bsq_w + ac4_w : bsq_w - ac4_w;
    end

    // ---- square root, one root bit per stage, two radicand bits in ----
    logic                sq_vld_reg  [SQ_N];
    sq_side_t            sq_side_reg [SQ_N];
    logic [SQ_N-1:0]     sq_root_reg [SQ_N];
    logic [SQ_REM_W-1:0] sq_rem_reg  [SQ_N];
    logic [SQ_D_W-1:0]   sq_d_reg    [SQ_N];

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        logic                vld_prev;
        sq_side_t            side_prev;
        logic [SQ_N-1:0]     root_prev;
        logic [SQ_REM_W-1:0] rem_prev;
        logic [SQ_D_W-1:0]   d_prev;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign vld_prev  = s3_vld_reg;
            assign side_prev = s3_side_reg;
            assign root_prev = '0;
            assign rem_prev  = '0;
            assign d_prev    = {{(SQ_D_W - D_W){1'b0}}, s3_d_reg};
        end else begin : g_rest
            assign vld_prev  = sq_vld_reg[k-1];
            assign side_prev = sq_side_reg[k-1];
            assign root_prev = sq_root_reg[k-1];
            assign rem_prev  = sq_rem_reg[k-1];
            assign d_prev    = sq_d_reg[k-1];
        end

        assign rem_sh = {rem_prev[SQ_REM_W-3:0], d_prev[SQ_D_W-1 -: 2]};
        assign trial  = {1'b0, root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_side_reg[k] <= side_prev;
            sq_root_reg[k] <= {root_prev[SQ_N-2:0], ge};
            sq_rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
            sq_d_reg[k]    <= {d_prev[SQ_D_W-3:0], 2'b00};
        end
    end

    // ---- root select: form q, pick numerators and divisors ----
    sq_side_t               sd;
    logic signed [QS_W-1:0] b_x;
    logic signed [QS_W-1:0] s_x;
    logic signed [QS_W-1:0] qp;
    logic signed [QS_W-1:0] qm;
    logic signed [QS_W-1:0] q_sel;
    logic [QS_W-1:0]        qp_m;
    logic [QS_W-1:0]        qm_m;
    logic [QS_W-1:0]        q_m;
    logic [MAG_W-1:0]       den_2a;
    logic [MAG_W-1:0]       c_2;
    logic                   b_neg;
    logic                   q_zero;
    tag_t                   qs_tag_next;
    logic [NUM_W-1:0]       num_a_next;
    logic [NUM_W-1:0]       num_b_next;
    logic [MAG_W-1:0]       den_b_next;
    logic                   sgn_b_next;

    assign sd     = sq_side_reg[SQ_N-1];
    assign b_x    = {{(QS_W - CW){sd.b[CW-1]}}, sd.b};
    assign s_x    = {{(QS_W - SQ_N){1'b0}}, sq_root_reg[SQ_N-1]};
    assign qp     = s_x - b_x;
    assign qm     = -(b_x + s_x);
    assign b_neg  = sd.b[CW-1];
    assign q_sel  = b_neg ? qp : qm;
    assign qp_m   = qp[QS_W-1] ? -qp : qp;
    assign qm_m   = qm[QS_W-1] ? -qm : qm;
    assign q_m    = q_sel[QS_W-1] ? -q_sel : q_sel;
    assign q_zero = q_sel == '0;
    assign den_2a = {{(MAG_W - CW - 1){1'b0}}, sd.am, 1'b0};
    assign c_2    = {{(MAG_W - CW - 1){1'b0}}, sd.cm, 1'b0};

    always_comb
    begin
        qs_tag_next.vld    = sq_vld_reg[SQ_N-1];
        qs_tag_next.method = sd.method;
        qs_tag_next.b_neg  = b_neg;
        // leading zero first, then negative discriminant, then zero Vieta divisor
        qs_tag_next.spec   = sd.a_zero || sd.no_real || (!sd.method && q_zero);
        if (sd.a_zero)
        begin
            qs_tag_next.spec_code = qrs_pkg::ST_ZERO_DIV;
        end
        else if (sd.no_real)
        begin
            qs_tag_next.spec_code = qrs_pkg::ST_NO_REAL;
        end
        else
        begin
            qs_tag_next.spec_code = qrs_pkg::ST_ZERO_DIV;
        end
        if (sd.method)
        begin
            // textbook: both roots over 2a
            qs_tag_next.sgn = qp[QS_W-1] != sd.a_neg;
            num_a_next      = {qp_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            num_b_next      = {qm_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            den_b_next      = den_2a;
            sgn_b_next      = qm[QS_W-1] != sd.a_neg;
        end
        else
        begin
            // stable: q/(2a) and 2c/q
            qs_tag_next.sgn = q_sel[QS_W-1] != sd.a_neg;
            num_a_next      = {q_m[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            num_b_next      = {c_2, {FRAC_BITS{1'b0}}};
            den_b_next      = q_m[MAG_W-1:0];
            sgn_b_next      = sd.c_neg != q_sel[QS_W-1];
        end
    end

    tag_t             qs_tag_reg;
    logic [NUM_W-1:0] qs_num_a_reg;
    logic [MAG_W-1:0] qs_den_a_reg;
    logic [NUM_W-1:0] qs_num_b_reg;
    logic [MAG_W-1:0] qs_den_b_reg;
    logic             qs_sgn_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qs_tag_reg <= '0;
        end
        else
        begin
            qs_tag_reg <= qs_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qs_num_a_reg <= num_a_next;
        qs_den_a_reg <= den_2a;
        qs_num_b_reg <= num_b_next;
        qs_den_b_reg <= den_b_next;
        qs_sgn_b_reg <= sgn_b_next;
    end

    // ---- dividers, same depth, so tags stay aligned ----
    logic [NUM_W-1:0] quo_a;
    logic [NUM_W-1:0] quo_b;
    tag_t             tag_a;
    logic             sgn_b;

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .TAG_W ($bits(tag_t))
    ) u_div_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_num  (qs_num_a_reg),
        .in_den  (qs_den_a_reg),
        .in_tag  (qs_tag_reg),
        .quo     (quo_a),
        .out_tag (tag_a)
    );

    qrs_div #(
        .NUM_W (NUM_W),
        .DEN_W (MAG_W),
        .TAG_W (1)
    ) u_div_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_num  (qs_num_b_reg),
        .in_den  (qs_den_b_reg),
        .in_tag  (qs_sgn_b_reg),
        .quo     (quo_b),
        .out_tag (sgn_b)
    );

    // signed, clamped quotient: {sat, value}
    function automatic logic [CW:0] sat_q(input logic [NUM_W-1:0] q, input logic sgn);
        logic             neg;
        logic             sat;
        logic [NUM_W-1:0] qc;
        logic [NUM_W-1:0] qn;
        neg = sgn && (q != '0);
        if (neg)
        begin
            sat = q > LIM;
            qc  = sat ? LIM : q;
            qn  = ~qc + 1'b1;
        end
        else
        begin
            sat = q > (LIM - 1'b1);
            qc  = sat ? (LIM - 1'b1) : q;
            qn  = qc;
        end
        return {sat, qn[CW-1:0]};
    endfunction

    logic [CW:0]      ra;
    logic [CW:0]      rb;
    qrs_pkg::result_t result_next;
    qrs_pkg::result_t result_reg;
    logic             done_reg;

    assign ra = sat_q(quo_a, tag_a.sgn);
    assign rb = sat_q(quo_b, sgn_b);

    always_comb
    begin
        result_next = '0;
        if (tag_a.spec)
        begin
            result_next.status = tag_a.spec_code;
        end
        else
        begin
            if (!tag_a.method && !tag_a.b_neg)
            begin
                result_next.root_one = rb[CW-1:0];
                result_next.root_two = ra[CW-1:0];
            end
            else
            begin
                result_next.root_one = ra[CW-1:0];
                result_next.root_two = rb[CW-1:0];
            end
            result_next.status = (ra[CW] || rb[CW]) ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag_a.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hw/rtl/qrs_check.sv @@
module qrs_check #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input qrs_pkg::result_t result
);

    localparam int LAT = 76 + FRAC_BITS;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item did not complete on time");

    a_done_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without item");

    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == qrs_pkg::ST_NO_REAL ||
                  result.status == qrs_pkg::ST_ZERO_DIV))
        |-> (result.root_one == '0 && result.root_two == '0))
        else $error("roots nonzero on special status");

endmodule

bind quadratic_roots_stable qrs_check #(.FRAC_BITS(FRAC_BITS)) u_qrs_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

@@ verif/quadratic_roots_checker.sv @@
`timescale 1ns / 1ps

module quadratic_roots_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  qrs_pkg::coef_t   coef,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             done,
    input  qrs_pkg::result_t result,
    output int               errors,
    output int               pending
);

    localparam int FRAC = qrs_pkg::FRAC_BITS_DEF;

    logic             textbook;
    qrs_pkg::result_t roots_due[$];

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // {saturated, quotient}, truncated toward zero, clamped to 32 signed bits
    function automatic logic [32:0] clamp_div(bit nneg, longint unsigned nmag,
                                              bit dneg, longint unsigned dmag);
        longint unsigned quo;
        longint unsigned lim;
        bit              neg;
        bit              sat;
        quo = nmag / dmag;
        lim = 64'd1 << 31;
        neg = (nneg != dneg) && (quo != 0);
        sat = 1'b0;
        if (neg)
        begin
            if (quo > lim)
            begin
                quo = lim;
                sat = 1'b1;
            end
            quo = 64'd0 - quo;
        end
        else if (quo > lim - 1)
        begin
            quo = lim - 1;
            sat = 1'b1;
        end
        return {sat, quo[31:0]};
    endfunction

    function automatic qrs_pkg::result_t solve_roots(qrs_pkg::coef_t cin, logic tb_mode);
        longint           a, b, c, qp, qm, q;
        longint unsigned  am, bm, cm, s;
        logic [127:0]     bsq, ac4, disc, t;
        logic [32:0]      rq, rv;
        qrs_pkg::result_t r;
        r = '0;
        a = cin.coef_a;
        b = cin.coef_b;
        c = cin.coef_c;
        am = abs64(a);
        bm = abs64(b);
        cm = abs64(c);
        if (a == 0)
        begin
            r.status = qrs_pkg::ST_ZERO_DIV;
            return r;
        end
        bsq = {64'd0, bm} * {64'd0, bm};
        ac4 = ({64'd0, am} * {64'd0, cm}) << 2;
        if ((a < 0) != (c < 0))
        begin
            disc = bsq + ac4;
        end
        else
        begin
            if (bsq < ac4)
            begin
                r.status = qrs_pkg::ST_NO_REAL;
                return r;
            end
            disc = bsq - ac4;
        end
        s = 0;
        for (int bitpos = 34; bitpos >= 0; bitpos--)
        begin
            t = {64'd0, s | (64'd1 << bitpos)};
            if (t * t <= disc) s = t[63:0];
        end
        qp = -b + longint'(s);
        qm = -b - longint'(s);
        if (!tb_mode)
        begin
            q = (b < 0) ? qp : qm;
            if (q == 0)
            begin
                r.status = qrs_pkg::ST_ZERO_DIV;
                return r;
            end
            rq = clamp_div(q < 0, abs64(q) << FRAC, a < 0, am << 1);
            rv = clamp_div(c < 0, (cm << 1) << FRAC, q < 0, abs64(q));
            if (b < 0)
            begin
                r.root_one = rq[31:0];
                r.root_two = rv[31:0];
            end
            else
            begin
                r.root_one = rv[31:0];
                r.root_two = rq[31:0];
            end
        end
        else
        begin
            rq = clamp_div(qp < 0, abs64(qp) << FRAC, a < 0, am << 1);
            rv = clamp_div(qm < 0, abs64(qm) << FRAC, a < 0, am << 1);
            r.root_one = rq[31:0];
            r.root_two = rv[31:0];
        end
        r.status = (rq[32] || rv[32]) ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $time, what);
        errors++;
    endtask

    assign pending = roots_due.size();

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        qrs_pkg::result_t want;
        if (!rst_n)
        begin
            textbook <= 1'b0;
            roots_due.delete();
        end
        else
        begin
            if (cfg_we) textbook <= cfg_data;
            if (done)
            begin
                if (roots_due.size() == 0)
                begin
                    report_mismatch("result with no item outstanding");
                end
                else
                begin
                    want = roots_due.pop_front();
                    if (result.root_one !== want.root_one)
                        report_mismatch($sformatf("root_one %h want %h",
                                                  result.root_one, want.root_one));
                    if (result.root_two !== want.root_two)
                        report_mismatch($sformatf("root_two %h want %h",
                                                  result.root_two, want.root_two));
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d want %0d",
                                                  result.status, want.status));
                end
            end
            if (start && !busy) roots_due.push_back(solve_roots(coef, textbook));
        end
    end

endmodule

@@ verif/quadratic_roots_stable_test.sv @@
`timescale 1ns / 1ps

module quadratic_roots_stable_test;

    // full block latency; drain margin on top of that
    localparam int LATENCY    = 76 + qrs_pkg::FRAC_BITS_DEF;
    localparam int STALL_MAX  = 5000;
    localparam int RAND_ITEMS = 200;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    qrs_pkg::coef_t   coef;
    logic             cfg_we;
    logic             cfg_data;
    logic             done;
    qrs_pkg::result_t result;
    int               errors;
    int               pending;
    int               stall_cycles = 0;

    quadratic_roots_stable u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .coef     (coef),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    quadratic_roots_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .coef     (coef),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: too long with neither an item taken nor a result seen
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Signed value spread over the low w bits (sign-extended)
    function automatic logic signed [31:0] span(int w);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - w);
    endfunction

    // Mostly well-formed coefficient sets that give real roots, with some
    // raw noise, zero leading coefficients and degenerate cases mixed in.
    function automatic qrs_pkg::coef_t pick_coef();
        qrs_pkg::coef_t v;
        int             k;
        v.coef_a = span($urandom_range(2, 32));
        v.coef_b = span($urandom_range(2, 32));
        v.coef_c = span($urandom_range(2, 32));
        case ($urandom_range(0, 19))
            0, 1, 2, 3: ;                              // raw noise
            4, 5, 6, 7, 8, 9:
            begin
                // opposite signs on a and c: discriminant never negative
                if ((v.coef_a < 0) == (v.coef_c < 0)) v.coef_c = -v.coef_c;
            end
            10, 11:
            begin
                // tiny a, big b: roots run off the Q16.16 range
                v.coef_a = span($urandom_range(2, 6));
                v.coef_b = $urandom;
            end
            12, 13:
            begin
                // double root: b*b equals 4ac exactly
                k = span($urandom_range(2, 30));
                v.coef_a = k;
                v.coef_c = k;
                v.coef_b = ($urandom_range(0, 1)) ? 2 * k : -2 * k;
            end
            14:
            begin
                v.coef_b = 0;
                v.coef_c = 0;
            end
            15: v.coef_a = 0;
            default:
            begin
                // big b against small ac: cancellation-prone in textbook mode
                v.coef_b = span($urandom_range(24, 32));
                v.coef_c = span($urandom_range(2, 12));
            end
        endcase
        return v;
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(qrs_pkg::coef_t v);
        start <= 1'b1;
        coef  <= v;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic idle_gap(bit allow);
        if (allow && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            coef  <= qrs_pkg::coef_t'({$urandom, $urandom, $urandom});
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // Drop start and let every outstanding item come back
    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_method(logic tb_mode);
        cfg_we   <= 1'b1;
        cfg_data <= tb_mode;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
    endtask

    task automatic run_directed();
        qrs_pkg::coef_t list[$];
        list.push_back('{32'sd0, 32'sd65536, 32'sd65536});                 // a = 0
        list.push_back('{32'h80000000, 32'h80000000, 32'h80000000});        // all min
        list.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});        // all max
        list.push_back('{32'h80000000, 32'h7fffffff, 32'h7fffffff});
        list.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000});
        list.push_back('{32'sd65536, 32'sd0, 32'sd0});                      // b = c = 0
        list.push_back('{32'sd65536, 32'sd0, 32'sd65536});                  // no real roots
        list.push_back('{32'sd65536, -32'sd196608, 32'sd131072});           // roots 1 and 2
        list.push_back('{-32'sd65536, 32'sd196608, -32'sd131072});
        list.push_back('{32'sd65536, 32'sd131072, 32'sd65536});             // double root
        list.push_back('{32'sd1, 32'h7fffffff, 32'sd1});                    // saturates
        list.push_back('{32'sd1, 32'h80000000, 32'sd1});
        list.push_back('{32'sd1, 32'sd0, 32'h80000000});
        list.push_back('{-32'sd1, 32'sd0, 32'h7fffffff});
        list.push_back('{32'sd65536, 32'h7fffffff, 32'sd1});                // cancellation
        list.push_back('{32'sd65536, 32'h80000001, -32'sd1});
        list.push_back('{32'h80000000, 32'sd0, 32'sd0});
        list.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff});
        foreach (list[i]) send_item(list[i]);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        coef     = '0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Phases alternate stable / textbook; each ends with a full drain,
        // which is also where the sender waits on every outstanding result.
        for (int phase = 0; phase < 4; phase++)
        begin
            write_method(phase[0]);
            if (phase < 2) run_directed();
            for (int n = 0; n < RAND_ITEMS; n++)
            begin
                send_item(pick_coef());
                // phase 2 carries a long back-to-back stretch
                idle_gap(!(phase == 2 && n >= 20 && n < 170));
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
